### src/vsac_pkg.sv
// Shared types and constants of the vehicle security alarm controller.
// Used by the channel interfaces and by every vsac module; no dependencies.
package vsac_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_ARM_DELAY   = 2'd0;
  localparam logic [1:0] CFG_ALARM_DUR   = 2'd1;
  localparam logic [1:0] CFG_SHOCK_LOCK  = 2'd2;
  localparam logic [1:0] CFG_SHOCK_LIMIT = 2'd3;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  // Reset values of the configuration registers
  localparam logic [7:0] ARM_DELAY_RST   = 8'd10;
  localparam logic [9:0] ALARM_DUR_RST   = 10'd90;
  localparam logic [7:0] SHOCK_LOCK_RST  = 8'd10;
  localparam logic [3:0] SHOCK_LIMIT_RST = 4'd4;

  // Stored alarm causes
  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_LITE = 2'd1;
  localparam logic [1:0] CAUSE_HARD = 2'd2;
  localparam logic [1:0] CAUSE_DOOR = 2'd3;

  // Chirp codes
  localparam logic [3:0] CHIRP_NONE        = 4'd0;
  localparam logic [3:0] CHIRP_ARM_SIREN   = 4'd1;
  localparam logic [3:0] CHIRP_ARM_BLINK   = 4'd2;
  localparam logic [3:0] CHIRP_SHOCK_WARN  = 4'd3;
  localparam logic [3:0] CHIRP_DIS_LITE    = 4'd4;
  localparam logic [3:0] CHIRP_DIS_HARD    = 4'd5;
  localparam logic [3:0] CHIRP_DIS_DOOR    = 4'd6;
  localparam logic [3:0] CHIRP_DIS_ENGINE  = 4'd7;
  localparam logic [3:0] CHIRP_DIS_PLAIN   = 4'd8;

  localparam logic [3:0] SHOCK_CNT_MAX = 4'd15;

  typedef struct packed {
    logic second_tick;
    logic disarm_pressed;
    logic arm_pressed;
    logic door_open;
    logic ignition_on;
    logic lite_shock_pulse;
    logic hard_shock_active;
    logic engine_running;
    logic heating_active;
  } in_item_t;

  typedef struct packed {
    logic       armed;
    logic       arming;
    logic       alarm_active;
    logic       immobilizer_on;
    logic [3:0] chirp_code;
    logic [1:0] alarm_cause;
  } out_item_t;

  typedef struct packed {
    logic [7:0] arm_delay_s;
    logic [9:0] alarm_duration_s;
    logic [7:0] shock_lock_s;
    logic [3:0] shock_count_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0] seconds_now;
    logic        armed;
    logic        arming;
    logic [31:0] arm_start;
    logic        alarm;
    logic [31:0] alarm_start;
    logic        lite_en;
    logic [3:0]  shock_cnt;
    logic        warned;
    logic [31:0] window_end;
    logic [1:0]  cause;
    logic        block;
  } state_t;

endpackage

### src/vsac_if.sv
// Valid/ready channel interfaces for poll items and result items.
// Depends on vsac_pkg for the payload types.
interface vsac_in_if;
  logic                valid;
  logic                ready;
  vsac_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface vsac_out_if;
  logic                valid;
  logic                ready;
  vsac_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### src/vehicle_security_alarm_controller_top.sv
// Top level of the vehicle security alarm controller.
// Depends on vsac_pkg, vsac_if, vsac_cfg and vsac_step.
//
// Usage:
//   in_i   poll channel (valid/ready): one transaction per poll of the debounced
//          switch and sensor lines plus the one-second tick.
//   out_o  result channel (valid/ready): exactly one transaction per poll with
//          the armed, arming, alarm and immobilizer flags, chirp code and cause.
//   cfg_*  write-only register port: arm delay, alarm duration, shock window
//          length and shock count limit. Write only while the block is idle.
// Timing: a poll is captured in an input register and evaluated combinationally
//   against the controller state, landing in the output register; the result
//   is valid once it is in the output register and, with a ready receiver, is
//   taken from there. Throughput is one poll per cycle while the receiver is
//   ready, set by the combinational state update between the two registers.
// Reset: all controller state, the seconds count and the cause memory clear;
//   configuration registers return to their default values.
// Stall: while the receiver holds off, the result holds, one more poll waits
//   in the input register, and in_i.ready drops until the result is taken.
module vehicle_security_alarm_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  vsac_in_if.sink                       in_i,
  vsac_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [vsac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vsac_pkg::CfgDataW-1:0] cfg_data_i
);

  vsac_pkg::cfg_t      cfg;
  vsac_pkg::state_t    st_q, st_d;
  vsac_pkg::in_item_t  in_q;
  vsac_pkg::out_item_t out_q, res;
  logic                in_vld_q, in_vld_d;
  logic                out_vld_q, out_vld_d;
  logic                advance;
  logic                in_ready;

  vsac_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  vsac_step u_step (
    .st_i   (st_q),
    .item_i (in_q),
    .cfg_i  (cfg),
    .st_o   (st_d),
    .res_o  (res)
  );

  // the evaluated poll moves on whenever the output register is free
  assign advance  = !out_vld_q || out_o.ready;
  assign in_ready = !in_vld_q || advance;
  assign in_vld_d = in_ready ? in_i.valid : in_vld_q;
  assign out_vld_d = advance ? in_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (in_vld_q && advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      in_q <= in_i.payload;
    end
    if (in_vld_q && advance) begin
      out_q <= res;
    end
  end

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

endmodule

### src/vsac_cfg.sv
// Configuration register file: four write-only registers with reset values.
// Depends on vsac_pkg.
module vsac_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vsac_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [vsac_pkg::CfgDataW-1:0]       cfg_data_i,
  output vsac_pkg::cfg_t                      cfg_o
);

  vsac_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        vsac_pkg::CFG_ARM_DELAY:   cfg_d.arm_delay_s       = cfg_data_i[7:0];
        vsac_pkg::CFG_ALARM_DUR:   cfg_d.alarm_duration_s  = cfg_data_i[9:0];
        vsac_pkg::CFG_SHOCK_LOCK:  cfg_d.shock_lock_s      = cfg_data_i[7:0];
        vsac_pkg::CFG_SHOCK_LIMIT: cfg_d.shock_count_limit = cfg_data_i[3:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arm_delay_s       <= vsac_pkg::ARM_DELAY_RST;
      cfg_q.alarm_duration_s  <= vsac_pkg::ALARM_DUR_RST;
      cfg_q.shock_lock_s      <= vsac_pkg::SHOCK_LOCK_RST;
      cfg_q.shock_count_limit <= vsac_pkg::SHOCK_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/vsac_step.sv
// Combinational evaluation of one poll: next controller state and result.
// Depends on vsac_pkg.
module vsac_step (
  input  vsac_pkg::state_t    st_i,
  input  vsac_pkg::in_item_t  item_i,
  input  vsac_pkg::cfg_t      cfg_i,
  output vsac_pkg::state_t    st_o,
  output vsac_pkg::out_item_t res_o
);

  vsac_pkg::state_t s;
  logic [3:0]       chirp;

  function automatic vsac_pkg::state_t raise_alarm(vsac_pkg::state_t x);
    vsac_pkg::state_t r;
    r             = x;
    r.alarm_start = x.seconds_now;
    r.alarm       = 1'b1;
    r.warned      = 1'b0;
    r.block       = 1'b1;
    r.lite_en     = 1'b0;
    return r;
  endfunction

  function automatic vsac_pkg::state_t disarm_state(vsac_pkg::state_t x);
    vsac_pkg::state_t r;
    r           = x;
    r.block     = 1'b0;
    r.lite_en   = 1'b0;
    r.armed     = 1'b0;
    r.alarm     = 1'b0;
    r.shock_cnt = '0;
    r.arming    = 1'b0;
    r.cause     = vsac_pkg::CAUSE_NONE;
    return r;
  endfunction

  function automatic logic [3:0] disarm_chirp(logic [1:0] cause, logic engine);
    logic [3:0] c;
    case (cause)
      vsac_pkg::CAUSE_LITE: c = vsac_pkg::CHIRP_DIS_LITE;
      vsac_pkg::CAUSE_HARD: c = vsac_pkg::CHIRP_DIS_HARD;
      vsac_pkg::CAUSE_DOOR: c = vsac_pkg::CHIRP_DIS_DOOR;
      default: c = engine ? vsac_pkg::CHIRP_DIS_ENGINE : vsac_pkg::CHIRP_DIS_PLAIN;
    endcase
    return c;
  endfunction

  always_comb begin
    s     = st_i;
    chirp = vsac_pkg::CHIRP_NONE;

    if (item_i.second_tick) begin
      s.seconds_now = s.seconds_now + 32'd1;
    end

    if (item_i.lite_shock_pulse && s.lite_en && !item_i.heating_active) begin
      s.lite_en = 1'b0;
      if (s.shock_cnt < vsac_pkg::SHOCK_CNT_MAX) begin
        s.shock_cnt = s.shock_cnt + 4'd1;
      end
    end

    if (s.armed) begin
      // shock rule, skipped in heating mode
      if (!item_i.heating_active && s.shock_cnt != 4'd0 && !s.alarm) begin
        s.block = 1'b1;
        if (s.shock_cnt == 4'd1 && !s.warned) begin
          s.window_end = s.seconds_now + 32'(cfg_i.shock_lock_s);
          chirp        = vsac_pkg::CHIRP_SHOCK_WARN;
          s.warned     = 1'b1;
          s.cause      = vsac_pkg::CAUSE_LITE;
        end
        if (s.seconds_now > s.window_end) begin
          if (s.shock_cnt < cfg_i.shock_count_limit) begin
            s.warned = 1'b0;
          end else begin
            s.window_end = s.seconds_now + 32'(cfg_i.shock_lock_s);
          end
          s.shock_cnt = '0;
        end
        s.lite_en = 1'b1;
        if (item_i.hard_shock_active) begin
          s       = raise_alarm(s);
          s.cause = vsac_pkg::CAUSE_HARD;
        end
      end

      if (!s.alarm && item_i.door_open) begin
        s       = raise_alarm(s);
        s.cause = vsac_pkg::CAUSE_DOOR;
      end

      // in heating mode a disarm comes first and leaves no alarm to time out
      if (!(item_i.heating_active && item_i.disarm_pressed) && s.alarm &&
          (s.seconds_now > s.alarm_start + 32'(cfg_i.alarm_duration_s))) begin
        s.alarm   = 1'b0;
        s.warned  = 1'b0;
        s.lite_en = 1'b1;
      end

      if (item_i.disarm_pressed) begin
        chirp = disarm_chirp(s.cause, item_i.engine_running);
        s     = disarm_state(s);
      end
    end

    if (!s.armed) begin
      if (!s.arming && item_i.arm_pressed && !item_i.door_open &&
          (item_i.heating_active || !item_i.ignition_on)) begin
        s.arm_start = s.seconds_now;
        s.arming    = 1'b1;
        s.shock_cnt = '0;
        chirp = item_i.engine_running ? vsac_pkg::CHIRP_ARM_SIREN
                                      : vsac_pkg::CHIRP_ARM_BLINK;
      end
      if (s.arming) begin
        if (s.seconds_now > s.arm_start + 32'(cfg_i.arm_delay_s)) begin
          s.arming = 1'b0;
          s.armed  = 1'b1;
          if (!item_i.heating_active) begin
            s.warned  = 1'b0;
            s.lite_en = 1'b1;
          end
        end
        if (item_i.disarm_pressed) begin
          chirp = disarm_chirp(s.cause, item_i.engine_running);
          s     = disarm_state(s);
        end
      end
    end

    st_o                 = s;
    res_o.armed          = s.armed;
    res_o.arming         = s.arming;
    res_o.alarm_active   = s.alarm;
    res_o.immobilizer_on = s.block;
    res_o.chirp_code     = chirp;
    res_o.alarm_cause    = s.cause;
  end

endmodule
